### hw/rtl/ubmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubmd_pkg: shared types and helpers for the upper-bound magnitude divider
// Operand classes, field widths, the word passed from the front end to the
// back end, and the classify / leading-zero helpers.
// ----------------------------------------------------------------------------
package ubmd_pkg;

  // Field widths
  localparam int MB = 30;               // mantissa bits
  localparam int EB = 32;               // exponent bits
  localparam int SW = $clog2(MB);       // normalize shift count width
  localparam int EW = EB + 2;           // exact exponent width before range check
  localparam int NSTEP = MB + 1;        // quotient bits, one per divider stage

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CLS_FINITE = 2'd0,
    CLS_ZERO   = 2'd1,
    CLS_INF    = 2'd2
  } cls_t;

  // Classified, normalized operand pair
  typedef struct packed {
    cls_t              cls;    // result class (finite means divide)
    logic [MB-1:0]     mx;     // normalized dividend mantissa
    logic [MB-1:0]     my;     // normalized divisor mantissa
    logic signed [EB:0] ediff; // ex - ey, exact
    logic [SW-1:0]     lx;     // dividend normalize shift
    logic [SW-1:0]     ly;     // divisor normalize shift
  } front_word_t;

  // Effective class of one operand; unused code treated as infinity
  function automatic cls_t classify(input logic [1:0] code, input logic [MB-1:0] m);
    cls_t c;
    if (code == CLS_ZERO) c = CLS_ZERO;
    else if (code != CLS_FINITE) c = CLS_INF;
    else if (m == '0) c = CLS_ZERO;
    else c = CLS_FINITE;
    return c;
  endfunction

  // Leading zero count (priority encoder); don't care for zero input
  function automatic logic [SW-1:0] lead_zeros(input logic [MB-1:0] m);
    logic [SW-1:0] n;
    n = '0;
    for (int i = 0; i < MB; i++) begin
      if (m[i]) n = SW'(MB - 1 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ubmd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubmd_front: operand intake and classification
// Two stages: classify and count leading zeros, then normalize mantissas,
// form the exponent difference and resolve special-operand results.
// ----------------------------------------------------------------------------
module ubmd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 dividend_class,
  input  logic [ubmd_pkg::MB-1:0]    dividend_mantissa,
  input  logic signed [ubmd_pkg::EB-1:0] dividend_exponent,
  input  logic [1:0]                 divisor_class,
  input  logic [ubmd_pkg::MB-1:0]    divisor_mantissa,
  input  logic signed [ubmd_pkg::EB-1:0] divisor_exponent,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ubmd_pkg::front_word_t      out_word
);
  import ubmd_pkg::*;

  logic              adv;
  logic              v1;
  cls_t              cx;
  cls_t              cy;
  logic [MB-1:0]     mx1;
  logic [MB-1:0]     my1;
  logic [EB-1:0]     ex1;
  logic [EB-1:0]     ey1;
  logic [SW-1:0]     lx1;
  logic [SW-1:0]     ly1;
  logic              v2;
  front_word_t       word;
  front_word_t       word_next;

  // Whole front advances unless its last word is held by the queue
  assign adv      = !(v2 && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage 1: classify and count leading zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      cx  <= classify(dividend_class, dividend_mantissa);
      cy  <= classify(divisor_class, divisor_mantissa);
      mx1 <= dividend_mantissa;
      my1 <= divisor_mantissa;
      ex1 <= dividend_exponent;
      ey1 <= divisor_exponent;
      lx1 <= lead_zeros(dividend_mantissa);
      ly1 <= lead_zeros(divisor_mantissa);
    end
  end

  // Stage 2: normalize, exponent difference, special result class
  always_comb begin
    word_next.mx    = mx1 << lx1;
    word_next.my    = my1 << ly1;
    word_next.ediff = {ex1[EB-1], ex1} - {ey1[EB-1], ey1};
    word_next.lx    = lx1;
    word_next.ly    = ly1;
    if (cx == CLS_FINITE && cy == CLS_FINITE) word_next.cls = CLS_FINITE;
    else if (cy == CLS_ZERO || cx == CLS_INF) word_next.cls = CLS_INF;
    else word_next.cls = CLS_ZERO;
  end

  always_ff @(posedge clk) begin
    if (adv) word <= word_next;
  end

  assign out_valid = v2;
  assign out_word  = word;

endmodule
`default_nettype wire

### hw/rtl/ubmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubmd_fifo: short queue between front end and divider back end
// Register-based FIFO; full raises in_stall, non-empty raises out_valid.
// ----------------------------------------------------------------------------
module ubmd_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ubmd_pkg::front_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ubmd_pkg::front_word_t out_word
);
  import ubmd_pkg::*;

  front_word_t   mem [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  logic          push;
  logic          pop;

  assign in_stall  = (count == (QW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_word  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QW'(1);
      if (pop)  rd_ptr <= rd_ptr + QW'(1);
      if (push && !pop) count <= count + (QW+1)'(1);
      else if (pop && !push) count <= count - (QW+1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_word;
  end

endmodule
`default_nettype wire

### hw/rtl/ubmd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubmd_back: pipelined restoring divider and result rounding
// One quotient bit per stage, then increment, renormalize and exponent
// range check, ending in the output register.
// ----------------------------------------------------------------------------
module ubmd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ubmd_pkg::front_word_t          in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     quotient_class,
  output logic [ubmd_pkg::MB-1:0]        quotient_mantissa,
  output logic signed [ubmd_pkg::EB-1:0] quotient_exponent,
  output logic                           exponent_range_error
);
  import ubmd_pkg::*;

  // One divider stage: rem holds the next trial value
  typedef struct packed {
    cls_t               cls;
    logic [MB-1:0]      my;
    logic [MB:0]        rem;
    logic [MB:0]        quo;
    logic signed [EB:0] ediff;
    logic [SW-1:0]      lx;
    logic [SW-1:0]      ly;
  } div_t;

  typedef struct packed {
    cls_t          cls;
    logic [MB:0]   q1;
    logic [EW-1:0] esum;
  } fin_t;

  function automatic div_t div_step(input div_t d);
    div_t        r;
    logic        ge;
    logic [MB:0] diff;
    r    = d;
    ge   = (d.rem >= {1'b0, d.my});
    diff = ge ? (d.rem - {1'b0, d.my}) : d.rem;
    r.rem = {diff[MB-1:0], 1'b0};
    r.quo = {d.quo[MB-1:0], ge};
    return r;
  endfunction

  logic             adv;
  div_t             head;
  div_t             ps [NSTEP];
  logic [NSTEP-1:0] pv;
  logic             fv;
  fin_t             fin;
  fin_t             fin_next;
  logic             ov;
  cls_t             ocls;
  logic [MB-1:0]    oman;
  logic [EB-1:0]    oexp;
  logic             oerr;

  // Global advance: held only by a stalled result
  assign adv      = !(ov && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
      fv <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      pv <= {pv[NSTEP-2:0], in_valid};
      fv <= pv[NSTEP-1];
      ov <= fv;
    end
  end

  // Divider entry: first trial is the dividend mantissa itself
  always_comb begin
    head.cls   = in_word.cls;
    head.my    = in_word.my;
    head.rem   = {1'b0, in_word.mx};
    head.quo   = '0;
    head.ediff = in_word.ediff;
    head.lx    = in_word.lx;
    head.ly    = in_word.ly;
  end

  // Divider stages
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    if (s == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv) ps[s] <= div_step(head);
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (adv) ps[s] <= div_step(ps[s-1]);
      end
    end
  end

  // Round up and fold normalize shifts into the exponent
  always_comb begin
    fin_next.cls  = ps[NSTEP-1].cls;
    fin_next.q1   = ps[NSTEP-1].quo + (MB+1)'(1);
    fin_next.esum = {ps[NSTEP-1].ediff[EB], ps[NSTEP-1].ediff}
                  + {{(EW-SW){1'b0}}, ps[NSTEP-1].ly}
                  - {{(EW-SW){1'b0}}, ps[NSTEP-1].lx};
  end

  always_ff @(posedge clk) begin
    if (adv) fin <= fin_next;
  end

  // Renormalize, final exponent and range check
  always_ff @(posedge clk) begin
    logic          fix1;
    logic          fix2;
    logic [MB:0]   q2;
    logic [MB:0]   q3;
    logic [EW-1:0] e;
    logic [2:0]    top;
    if (adv) begin
      fix1 = fin.q1[MB];
      q2   = fix1 ? ((fin.q1 >> 1) + (MB+1)'(1)) : fin.q1;
      fix2 = q2[MB];
      q3   = fix2 ? (q2 >> 1) : q2;
      e    = fin.esum + {{(EW-2){1'b0}}, ({1'b0, fix1} + {1'b0, fix2})};
      top  = e[EW-1:EB-1];
      ocls <= fin.cls;
      if (fin.cls == CLS_FINITE) begin
        oman <= q3[MB-1:0];
        oexp <= e[EB-1:0];
        oerr <= !(&top || ~|top);
      end else begin
        oman <= '0;
        oexp <= '0;
        oerr <= 1'b0;
      end
    end
  end

  assign out_valid            = ov;
  assign quotient_class       = ocls;
  assign quotient_mantissa    = oman;
  assign quotient_exponent    = oexp;
  assign exponent_range_error = oerr;

endmodule
`default_nettype wire

### hw/rtl/upper_bound_magnitude_divider_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upper_bound_magnitude_divider_core: upper-bound magnitude float divider
// Divides two class/mantissa/exponent magnitudes and returns a normalized
// result never below the true quotient.
//
// Usage:
//   Input and output channels use valid/stall; a word moves at a clock edge
//   with valid high and stall low. One operand pair gives one result word.
//   Throughput is one word per cycle while the receiver does not stall.
//   A result passes the two front-end stages (classify, normalize), the
//   queue, 31 divider stages (one quotient bit each) and a rounding
//   register before the output register.
//   Special operands ride the same pipeline, so order is always preserved.
//   When the receiver stalls, the result register and the divider pipeline
//   hold; the front end keeps taking words until the four-entry queue is
//   full and its last stage holds a word, then raises in_stall.
//   Synchronous reset empties every stage and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module upper_bound_magnitude_divider_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     dividend_class,
  input  logic [ubmd_pkg::MB-1:0]        dividend_mantissa,
  input  logic signed [ubmd_pkg::EB-1:0] dividend_exponent,
  input  logic [1:0]                     divisor_class,
  input  logic [ubmd_pkg::MB-1:0]        divisor_mantissa,
  input  logic signed [ubmd_pkg::EB-1:0] divisor_exponent,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     quotient_class,
  output logic [ubmd_pkg::MB-1:0]        quotient_mantissa,
  output logic signed [ubmd_pkg::EB-1:0] quotient_exponent,
  output logic                           exponent_range_error
);
  import ubmd_pkg::*;

  front_word_t fw;
  logic        fv;
  logic        fs;
  front_word_t qw;
  logic        qv;
  logic        qs;

  // Intake and classification
  ubmd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .dividend_class    (dividend_class),
    .dividend_mantissa (dividend_mantissa),
    .dividend_exponent (dividend_exponent),
    .divisor_class     (divisor_class),
    .divisor_mantissa  (divisor_mantissa),
    .divisor_exponent  (divisor_exponent),
    .out_valid         (fv),
    .out_stall         (fs),
    .out_word          (fw)
  );

  // Decoupling queue
  ubmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv),
    .in_stall  (fs),
    .in_word   (fw),
    .out_valid (qv),
    .out_stall (qs),
    .out_word  (qw)
  );

  // Divider and rounding
  ubmd_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (qv),
    .in_stall             (qs),
    .in_word              (qw),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .quotient_class       (quotient_class),
    .quotient_mantissa    (quotient_mantissa),
    .quotient_exponent    (quotient_exponent),
    .exponent_range_error (exponent_range_error)
  );

endmodule
`default_nettype wire
